// ===== rtl/lagged_fibonacci_bounded_random_unit_defines.svh =====
// assertion macros for the checker of the lagged fibonacci random unit
`ifndef LAGGED_FIBONACCI_BOUNDED_RANDOM_UNIT_DEFINES_SVH
`define LAGGED_FIBONACCI_BOUNDED_RANDOM_UNIT_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define LFBR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define LFBR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lfbr_pkg.sv =====
// shared types and constants of the lagged fibonacci random unit
package lfbr_pkg;

    localparam int WORD_W        = 32;
    localparam int SEED_INDEX_W  = 7;
    localparam int OP_W          = 2;
    localparam int IN_DATA_W     = 72;
    localparam int OUT_DATA_W    = 32;

    localparam int LONG_LAG_DEF  = 97;
    localparam int SHORT_LAG_DEF = 33;
    localparam logic [WORD_W-1:0] MAX_VALUE_DEF = 32'hFFFF_FFFF;

    // retry budget of a bounded draw
    localparam int MAX_TRIES     = 4096;
    localparam int TRIES_W       = $clog2(MAX_TRIES + 1);

    typedef enum logic [OP_W-1:0] {
        OP_SEED    = 2'd0,
        OP_RAW     = 2'd1,
        OP_BOUNDED = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRAW,
        ST_DIV,
        ST_CHECK,
        ST_OUTPUT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        RING_IDLE,
        RING_LONG,
        RING_SHORT
    } ring_state_t;

    typedef struct packed {
        logic                    start;
        logic                    seed_en;
        logic [SEED_INDEX_W-1:0] seed_index;
        logic [WORD_W-1:0]       seed_word;
    } ring_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] value;
    } ring_rsp_t;

endpackage

// ===== rtl/lfbr_ram.sv =====
// generic single write port ram with registered read
module lfbr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 97
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/lfbr_divider.sv =====
// bit-serial restoring remainder unit, one dividend bit per cycle
module lfbr_divider
    import lfbr_pkg::*;
#(
    parameter int W = WORD_W
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] remainder
);

    localparam int CW = $clog2(W);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] count_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  shift_reg;
    logic [W-1:0]  divisor_reg;

    logic [W:0]    trial;
    logic [W:0]    trial_diff;
    logic [W-1:0]  rem_next;

    // partial remainder stays below the divisor, so the trial fits w+1 bits
    always_comb
    begin
        trial      = {rem_reg, shift_reg[W-1]};
        trial_diff = trial - {1'b0, divisor_reg};
        rem_next   = trial_diff[W] ? trial[W-1:0] : trial_diff[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= CW'(W - 1);
            end
            else if (busy_reg)
            begin
                if (count_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= '0;
            shift_reg   <= dividend;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg   <= rem_next;
            shift_reg <= {shift_reg[W-2:0], 1'b0};
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/lfbr_lag_ring.sv =====
// lag table with long and short pointers and the modular add of a raw draw
module lfbr_lag_ring
    import lfbr_pkg::*;
#(
    parameter int LONG_LAG  = LONG_LAG_DEF,
    parameter int SHORT_LAG = SHORT_LAG_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  ring_req_t req,
    output ring_rsp_t rsp
);

    localparam int IW = $clog2(LONG_LAG);
    localparam logic [IW-1:0] LONG_START  = IW'(LONG_LAG - 1);
    localparam logic [IW-1:0] SHORT_START = IW'((SHORT_LAG - 1) % LONG_LAG);

    ring_state_t       state_reg;
    ring_state_t       state_next;
    logic [IW-1:0]     lp_reg;
    logic [IW-1:0]     sp_reg;
    logic [WORD_W-1:0] long_word_reg;

    logic              we;
    logic [IW-1:0]     waddr;
    logic [WORD_W-1:0] wdata;
    logic [IW-1:0]     raddr;
    logic [WORD_W-1:0] rdata;
    logic [WORD_W-1:0] sum;

    function automatic logic [IW-1:0] step_down(input logic [IW-1:0] p);
        return (p == '0) ? LONG_START : p - 1'b1;
    endfunction

    lfbr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (LONG_LAG)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RING_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // long word is read in the request cycle, short word in the cycle after
    always_comb
    begin
        state_next = state_reg;
        we         = 1'b0;
        waddr      = lp_reg;
        wdata      = req.seed_word;
        raddr      = lp_reg;
        sum        = long_word_reg + rdata;
        rsp.done   = 1'b0;
        rsp.value  = sum;
        unique case (state_reg)
            RING_IDLE:
            begin
                if (req.seed_en)
                begin
                    we    = 1'b1;
                    waddr = req.seed_index[IW-1:0];
                end
                if (req.start)
                begin
                    state_next = RING_LONG;
                end
            end
            RING_LONG:
            begin
                raddr      = sp_reg;
                state_next = RING_SHORT;
            end
            RING_SHORT:
            begin
                we         = 1'b1;
                wdata      = sum;
                rsp.done   = 1'b1;
                state_next = RING_IDLE;
            end
            default:
            begin
                state_next = RING_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lp_reg <= LONG_START;
            sp_reg <= SHORT_START;
        end
        else if (state_reg == RING_SHORT)
        begin
            lp_reg <= step_down(lp_reg);
            sp_reg <= step_down(sp_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == RING_LONG)
        begin
            long_word_reg <= rdata;
        end
    end

endmodule

// ===== rtl/lagged_fibonacci_bounded_random_unit.sv =====
// Additive lagged fibonacci generator with rejection-bounded draws.
// Requests come in on the s_axis channel: tuser carries the operation
// (seed write, raw draw, bounded draw), tdata the seed index, seed word
// and limit. Each draw gives one number on the m_axis channel; seed
// writes and unknown operations give nothing.
// One request is worked on at a time. A raw draw holds the input until
// its result is loaded: the lag table has one read port, so the long and
// short words are read in turn before the add.
// A bounded draw with a zero limit gives zero. Otherwise each try reads
// the table, runs the value through the 32-step bit-serial remainder unit
// and makes the rejection check. A rejected value starts another try, up
// to 4096 tries, and the result is handed over before the next request
// is taken.
// After reset the pointers sit at their start positions and the table
// holds nothing useful until every entry that a draw will read is seeded.
// A result waits in the output register while the receiver stalls; the
// next request is still taken, and its result waits until that register
// is free.
module lagged_fibonacci_bounded_random_unit
    import lfbr_pkg::*;
#(
    parameter int                LONG_LAG  = LONG_LAG_DEF,
    parameter int                SHORT_LAG = SHORT_LAG_DEF,
    parameter logic [WORD_W-1:0] MAX_VALUE = MAX_VALUE_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // seed_index [6:0], seed_word [38:7], limit [70:39], zero [71]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // operation [1:0]
    input  logic [OP_W-1:0]       s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // number [31:0]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    ctrl_state_t       state_reg;
    ctrl_state_t       state_next;
    op_t               op_reg;
    logic [WORD_W-1:0] limit_reg;
    logic [WORD_W-1:0] v_reg;
    logic [WORD_W-1:0] diff_reg;
    logic [WORD_W-1:0] result_reg;
    logic [TRIES_W-1:0] tries_reg;
    logic              out_valid_reg;
    logic [WORD_W-1:0] out_data_reg;

    op_t                     in_op;
    logic [SEED_INDEX_W-1:0] in_seed_index;
    logic [WORD_W-1:0]       in_seed_word;
    logic [WORD_W-1:0]       in_limit;
    logic                    accept;
    logic                    load_out;
    logic                    div_start;
    logic                    div_done;
    logic [WORD_W-1:0]       div_rem;
    logic                    reject;
    ring_req_t               ring_req;
    ring_rsp_t               ring_rsp;

    assign in_op         = op_t'(s_axis_tuser);
    assign in_seed_index = s_axis_tdata[6:0];
    assign in_seed_word  = s_axis_tdata[38:7];
    assign in_limit      = s_axis_tdata[70:39];
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    lfbr_lag_ring #(
        .LONG_LAG  (LONG_LAG),
        .SHORT_LAG (SHORT_LAG)
    ) u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ring_req),
        .rsp   (ring_rsp)
    );

    lfbr_divider #(
        .W (WORD_W)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (ring_rsp.value),
        .divisor   (limit_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    // v - (v mod limit) is the base of v's block; the value is rejected
    // when base + limit passes the maximum, which covers the last, partial block
    assign reject = (v_reg > MAX_VALUE)
                 || (({1'b0, diff_reg} + {1'b0, limit_reg}) > {1'b0, MAX_VALUE});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next          = state_reg;
        ring_req.start      = 1'b0;
        ring_req.seed_en    = 1'b0;
        ring_req.seed_index = in_seed_index;
        ring_req.seed_word  = in_seed_word;
        div_start           = 1'b0;
        load_out            = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_op)
                        OP_SEED:
                        begin
                            ring_req.seed_en = (in_seed_index < SEED_INDEX_W'(LONG_LAG));
                        end
                        OP_RAW:
                        begin
                            ring_req.start = 1'b1;
                            state_next     = ST_DRAW;
                        end
                        OP_BOUNDED:
                        begin
                            if (in_limit == '0)
                            begin
                                state_next = ST_OUTPUT;
                            end
                            else
                            begin
                                ring_req.start = 1'b1;
                                state_next     = ST_DRAW;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DRAW:
            begin
                if (ring_rsp.done)
                begin
                    if (op_reg == OP_RAW)
                    begin
                        state_next = ST_OUTPUT;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!reject || (tries_reg == TRIES_W'(MAX_TRIES)))
                begin
                    state_next = ST_OUTPUT;
                end
                else
                begin
                    ring_req.start = 1'b1;
                    state_next     = ST_DRAW;
                end
            end
            ST_OUTPUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= in_op;
            limit_reg  <= in_limit;
            result_reg <= '0;
        end
        if (ring_req.start)
        begin
            tries_reg <= (state_reg == ST_IDLE) ? TRIES_W'(1) : tries_reg + 1'b1;
        end
        if ((state_reg == ST_DRAW) && ring_rsp.done)
        begin
            v_reg      <= ring_rsp.value;
            result_reg <= ring_rsp.value;
        end
        if ((state_reg == ST_DIV) && div_done)
        begin
            result_reg <= div_rem;
            diff_reg   <= v_reg - div_rem;
        end
        if (load_out)
        begin
            out_data_reg <= result_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ===== rtl/lfbr_checker.sv =====
// port-level checker for the lagged fibonacci random unit, bound to the top level
`include "lagged_fibonacci_bounded_random_unit_defines.svh"

module lfbr_checker
    import lfbr_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [IN_DATA_W-1:0]  s_axis_tdata,
    input logic [OP_W-1:0]       s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic accept;
    logic draw_req;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign draw_req = (s_axis_tuser == OP_RAW)
                   || ((s_axis_tuser == OP_BOUNDED) && (s_axis_tdata[70:39] != '0));

    `LFBR_ASSERT_NEXT(a_out_valid_holds, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
    `LFBR_ASSERT_NEXT(a_out_data_holds, clk, rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed while stalled")
    `LFBR_ASSERT_NEXT(a_draw_busy, clk, rst_n, accept && draw_req, !s_axis_tready, "request taken during a draw")
    `LFBR_ASSERT_NEXT(a_no_result_ready, clk, rst_n, accept && (s_axis_tuser != OP_RAW) && (s_axis_tuser != OP_BOUNDED), s_axis_tready, "seed write did not free the input")

endmodule

bind lagged_fibonacci_bounded_random_unit lfbr_checker u_lfbr_checker (.*);
